// File: rtl/ppa_pkg.sv
// ----------------------------------------------------------------------------
// Parking proximity alarm package
// Shared widths, codes, scaling constants and the types passed between modules.
// ----------------------------------------------------------------------------
package ppa_pkg;

  // Field widths
  localparam int KIND_W    = 2;
  localparam int ECHO_W    = 16;
  localparam int SAMPLE_W  = 10;
  localparam int DIST_W    = 11;
  localparam int ALERT_W   = 9;
  localparam int ZONE_W    = 3;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 4;
  localparam int DELTA_W   = DIST_W + 1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd1;
  localparam logic [KIND_W-1:0] KIND_KNOB = 2'd2;

  // Zone codes
  localparam logic [ZONE_W-1:0] ZONE_CONTACT = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_NEAR    = 3'd1;
  localparam logic [ZONE_W-1:0] ZONE_MID     = 3'd2;
  localparam logic [ZONE_W-1:0] ZONE_FAR     = 3'd3;
  localparam logic [ZONE_W-1:0] ZONE_CLEAR   = 3'd4;

  // Zone band limits on the signed difference
  localparam logic signed [DELTA_W-1:0] CONTACT_LIMIT = 12'sd0;
  localparam logic signed [DELTA_W-1:0] NEAR_LIMIT    = 12'sd30;
  localparam logic signed [DELTA_W-1:0] MID_LIMIT     = 12'sd60;
  localparam logic signed [DELTA_W-1:0] CLEAR_LIMIT   = 12'sd90;

  // Period register indexes and reset values
  localparam int NUM_PERIODS = 4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_CONTACT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NEAR    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MID     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FAR     = 4'd3;
  localparam logic [PERIOD_W-1:0] PERIOD_CONTACT_RST = 16'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_NEAR_RST    = 16'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_MID_RST     = 16'd400;
  localparam logic [PERIOD_W-1:0] PERIOD_FAR_RST     = 16'd1200;

  // Echo counts / 58 as multiply by ceil(2^27/58) then shift; exact for 16-bit counts
  localparam int ECHO_RECIP_W = 22;
  localparam int ECHO_SHIFT   = 27;
  localparam int ECHO_PROD_W  = ECHO_W + ECHO_RECIP_W;
  localparam logic [ECHO_RECIP_W-1:0] ECHO_RECIP = 22'd2314099;

  // Sample * 400 / 1024 reduced to sample * 25 / 64
  localparam int KNOB_MUL_W  = 5;
  localparam int KNOB_SHIFT  = 6;
  localparam int KNOB_PROD_W = SAMPLE_W + KNOB_MUL_W;
  localparam logic [KNOB_MUL_W-1:0] KNOB_MUL = 5'd25;

  // Converted input item
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DIST_W-1:0]  distance;
    logic [ALERT_W-1:0] alert;
  } item_t;

  // Configuration write
  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [PERIOD_W-1:0]  data;
  } cfg_wr_t;

  // Result item
  typedef struct packed {
    logic               led_on;
    logic               buzzer_on;
    logic [ZONE_W-1:0]  zone;
    logic [DIST_W-1:0]  distance_cm;
    logic [ALERT_W-1:0] alert_cm;
  } result_t;

endpackage

// File: rtl/ppa_sensor_if.sv
// ----------------------------------------------------------------------------
// Sensor item channel
// Valid/ready channel carrying ticks, echo widths and knob samples.
// ----------------------------------------------------------------------------
interface ppa_sensor_if import ppa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ECHO_W-1:0]   echo_counts;
  logic [SAMPLE_W-1:0] setting_sample;

  modport source (output valid, output kind, output echo_counts, output setting_sample,
                  input ready);
  modport sink   (input valid, input kind, input echo_counts, input setting_sample,
                  output ready);
endinterface

// File: rtl/ppa_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying LED, buzzer, zone and stored distances.
// ----------------------------------------------------------------------------
interface ppa_result_if import ppa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               led_on;
  logic               buzzer_on;
  logic [ZONE_W-1:0]  zone;
  logic [DIST_W-1:0]  distance_cm;
  logic [ALERT_W-1:0] alert_cm;

  modport source (output valid, output led_on, output buzzer_on, output zone,
                  output distance_cm, output alert_cm, input ready);
  modport sink   (input valid, input led_on, input buzzer_on, input zone,
                  input distance_cm, input alert_cm, output ready);
endinterface

// File: rtl/ppa_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ppa_cfg_if import ppa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PERIOD_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ppa_convert.sv
// ----------------------------------------------------------------------------
// Sensor scaling
// Converts echo counts to centimeters and the knob sample to an alert distance.
// ----------------------------------------------------------------------------
module ppa_convert import ppa_pkg::*; (
  input  logic [KIND_W-1:0]   kind,
  input  logic [ECHO_W-1:0]   echo_counts,
  input  logic [SAMPLE_W-1:0] setting_sample,
  output item_t               item
);

  logic [ECHO_PROD_W-1:0] echo_prod;
  logic [KNOB_PROD_W-1:0] knob_prod;

  // Divide by 58 through the reciprocal multiply
  assign echo_prod = ECHO_PROD_W'(echo_counts) * ECHO_PROD_W'(ECHO_RECIP);

  // Scale the knob sample to 0..399 cm
  assign knob_prod = KNOB_PROD_W'(setting_sample) * KNOB_PROD_W'(KNOB_MUL);

  assign item.kind     = kind;
  assign item.distance = echo_prod[ECHO_SHIFT +: DIST_W];
  assign item.alert    = knob_prod[KNOB_SHIFT +: ALERT_W];

endmodule

// File: rtl/ppa_core.sv
// ----------------------------------------------------------------------------
// Alarm core
// Input register, stored distances, zone logic, LED blink counter, result register.
// ----------------------------------------------------------------------------
module ppa_core import ppa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_ready,
  input  cfg_wr_t cfg_wr,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic                s1_valid;
  item_t               s1;
  logic                advance;
  logic [PERIOD_W-1:0] period [NUM_PERIODS];
  logic [DIST_W-1:0]   distance_reg, distance_next;
  logic [ALERT_W-1:0]  alert_reg, alert_next;
  logic                led_level, led_next;
  logic [PERIOD_W-1:0] since_toggle_ms, since_toggle_ms_next, count_inc;
  logic signed [DELTA_W-1:0] delta;
  logic [ZONE_W-1:0]   zone;
  logic                toggle;

  // Move the held item on when the result register is free or being drained
  assign advance    = s1_valid && (!res_valid || res_ready);
  assign item_ready = !s1_valid || advance;

  // Hold the converted item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      s1 <= item;
    end
  end

  // Period registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period[REG_PERIOD_CONTACT[1:0]] <= PERIOD_CONTACT_RST;
      period[REG_PERIOD_NEAR[1:0]]    <= PERIOD_NEAR_RST;
      period[REG_PERIOD_MID[1:0]]     <= PERIOD_MID_RST;
      period[REG_PERIOD_FAR[1:0]]     <= PERIOD_FAR_RST;
    end else if (cfg_wr.en && cfg_wr.index <= REG_PERIOD_FAR) begin
      period[cfg_wr.index[1:0]] <= cfg_wr.data;
    end
  end

  // Apply the item to the stored values
  always_comb begin
    distance_next = (s1.kind == KIND_ECHO) ? s1.distance : distance_reg;
    alert_next    = (s1.kind == KIND_KNOB) ? s1.alert : alert_reg;
    count_inc     = since_toggle_ms;
    if (s1.kind == KIND_TICK && since_toggle_ms != '1) begin
      count_inc = since_toggle_ms + PERIOD_W'(1);
    end
  end

  // Pick the zone from the signed difference
  assign delta = $signed({1'b0, distance_next}) - $signed({{(DELTA_W-ALERT_W){1'b0}}, alert_next});

  always_comb begin
    if (delta <= CONTACT_LIMIT) begin
      zone = ZONE_CONTACT;
    end else if (delta <= NEAR_LIMIT) begin
      zone = ZONE_NEAR;
    end else if (delta <= MID_LIMIT) begin
      zone = ZONE_MID;
    end else if (delta < CLEAR_LIMIT) begin
      zone = ZONE_FAR;
    end else begin
      zone = ZONE_CLEAR;
    end
  end

  // Toggle the LED when the counter reaches the zone period; force off when clear
  always_comb begin
    toggle               = (zone != ZONE_CLEAR) && (count_inc >= period[zone[1:0]]);
    led_next             = (zone == ZONE_CLEAR) ? 1'b0 : (led_level ^ toggle);
    since_toggle_ms_next = toggle ? '0 : count_inc;
  end

  // Update state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_reg    <= '0;
      alert_reg       <= '0;
      led_level       <= 1'b0;
      since_toggle_ms <= '0;
    end else if (advance) begin
      distance_reg    <= distance_next;
      alert_reg       <= alert_next;
      led_level       <= led_next;
      since_toggle_ms <= since_toggle_ms_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      res.led_on      <= led_next;
      res.buzzer_on   <= (zone == ZONE_CONTACT);
      res.zone        <= zone;
      res.distance_cm <= distance_next;
      res.alert_cm    <= alert_next;
    end
  end

endmodule

// File: rtl/parking_proximity_alarm.sv
// ----------------------------------------------------------------------------
// Parking proximity alarm
// Converts echo widths and knob samples to distances and drives LED and buzzer.
// ----------------------------------------------------------------------------
// Channels: sensor takes one item per transfer (kind 0 millisecond tick, 1 echo
// width, 2 knob sample); result gives exactly one item per sensor transfer with
// LED level, buzzer enable, zone and the stored distance and alert distance.
// cfg writes the four LED blink periods (index 0 contact .. 3 far); other
// indexes are dropped. cfg is always ready; write it only while idle.
// Throughput: one item per cycle while result ready holds high. Each item is scaled
// on the way into the input register, then zone and blink logic loads the result
// register from it; a result turns valid only after both registers are loaded.
// Reset clears the stored distances, LED level and millisecond counter, and
// reloads the default periods (10, 100, 400, 1200 ms).
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that sensor ready drops until result drains.
// ----------------------------------------------------------------------------
module parking_proximity_alarm import ppa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ppa_sensor_if.sink    sensor,
  ppa_cfg_if.sink       cfg,
  ppa_result_if.source  result
);

  item_t   item;
  cfg_wr_t cfg_wr;
  result_t res;
  logic    sensor_ready;
  logic    res_valid;

  // Scale the incoming measurement
  ppa_convert u_convert (
    .kind           (sensor.kind),
    .echo_counts    (sensor.echo_counts),
    .setting_sample (sensor.setting_sample),
    .item           (item)
  );

  // Accept every configuration write
  assign cfg.ready    = 1'b1;
  assign cfg_wr.en    = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  ppa_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (sensor.valid),
    .item       (item),
    .item_ready (sensor_ready),
    .cfg_wr     (cfg_wr),
    .res_valid  (res_valid),
    .res_ready  (result.ready),
    .res        (res)
  );

  assign sensor.ready       = sensor_ready;
  assign result.valid       = res_valid;
  assign result.led_on      = res.led_on;
  assign result.buzzer_on   = res.buzzer_on;
  assign result.zone        = res.zone;
  assign result.distance_cm = res.distance_cm;
  assign result.alert_cm    = res.alert_cm;

  // Buzzer is on exactly in the contact zone
  a_buzzer_zone: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.buzzer_on == (result.zone == ZONE_CONTACT)))
    else $error("buzzer enable does not match zone");

  // LED is dark whenever the zone is clear
  a_clear_led_off: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.zone == ZONE_CLEAR) |-> !result.led_on)
    else $error("LED lit in clear zone");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

  // A waiting result blocks intake once the input register is full
  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready && sensor.valid && sensor.ready)
      |=> (!sensor.ready || result.ready))
    else $error("input taken with full pipeline");

endmodule
